// ----- hw/rtl/mnbo_pkg.sv -----
// ----------------------------------------------------------------------------
// mnbo_pkg
// Shared types and constants of the mesh node bandwidth ordering block.
// ----------------------------------------------------------------------------
package mnbo_pkg;

	localparam int NODE_W    = 12;
	localparam int TOTAL_W   = 13;
	localparam int MAX_NODES = 4096;
	localparam int ELEM_MAX  = 4;

	// request kinds
	localparam logic [1:0] KIND_CLEAR   = 2'd0;
	localparam logic [1:0] KIND_ELEMENT = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;
	localparam logic [1:0] KIND_QUERY   = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_NO_ORDER = 2'd2;

	// datapath operations
	typedef logic [4:0] op_t;
	localparam op_t OP_NONE   = 5'd0;
	localparam op_t OP_INIT   = 5'd1;
	localparam op_t OP_ACCEPT = 5'd2;
	localparam op_t OP_DISP   = 5'd3;
	localparam op_t OP_SWEEP  = 5'd4;
	localparam op_t OP_LRD    = 5'd5;
	localparam op_t OP_LCNT   = 5'd6;
	localparam op_t OP_LSCAN  = 5'd7;
	localparam op_t OP_LWR    = 5'd8;
	localparam op_t OP_LNEXT  = 5'd9;
	localparam op_t OP_CSCAN  = 5'd10;
	localparam op_t OP_SEED   = 5'd11;
	localparam op_t OP_POP    = 5'd12;
	localparam op_t OP_NODE   = 5'd13;
	localparam op_t OP_DEG    = 5'd14;
	localparam op_t OP_NB     = 5'd15;
	localparam op_t OP_CHK    = 5'd16;
	localparam op_t OP_FIN    = 5'd17;

	typedef struct packed {
		op_t op;
	} mnbo_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       hn_zero;
		logic       init_last;
		logic       clr_last;
		logic       deg_zero;
		logic       match;
		logic       more;
		logic       pair_last;
		logic       scan_done;
		logic       q_empty;
		logic       out_free;
	} mnbo_stat_t;

endpackage

// ----- hw/rtl/mesh_node_bandwidth_ordering.sv -----
// ----------------------------------------------------------------------------
// mesh_node_bandwidth_ordering
// Reverse breadth-first node ordering of a mesh with per-node neighbour lists.
// ----------------------------------------------------------------------------
// One request at a time, one result each. After reset the block clears its
// neighbour counts before it takes a request. A clear zeroes the count entries
// below the highest node, one count entry a cycle. An element runs up to
// twenty-four list insertions, and the duplicate scan reads one stored
// neighbour a cycle. A compute searches the nodes for a start, then walks the
// reached nodes and their stored neighbours. The result waits in an output
// register until taken.
module mesh_node_bandwidth_ordering import mnbo_pkg::*; #(
	parameter int MAX_DEGREE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [NODE_W-1:0]   node0,
	input  logic [NODE_W-1:0]   node1,
	input  logic [NODE_W-1:0]   node2,
	input  logic [NODE_W-1:0]   node3,
	input  logic [NODE_W-1:0]   query_node,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic                used,
	output logic [NODE_W-1:0]   new_index,
	output logic [TOTAL_W-1:0]  used_count,
	output logic [TOTAL_W-1:0]  node_count
);

	mnbo_cmd_t  cmd;
	mnbo_stat_t stat;

	mnbo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mnbo_dp #(.MAX_DEGREE(MAX_DEGREE)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.kind       (kind),
		.node0      (node0),
		.node1      (node1),
		.node2      (node2),
		.node3      (node3),
		.query_node (query_node),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.used       (used),
		.new_index  (new_index),
		.used_count (used_count),
		.node_count (node_count)
	);

endmodule

// ----- hw/rtl/mnbo_ctrl.sv -----
// ----------------------------------------------------------------------------
// mnbo_ctrl
// Sequencer: steps the datapath through clear, insert, walk and query work.
// ----------------------------------------------------------------------------
module mnbo_ctrl import mnbo_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  mnbo_stat_t stat,
	output mnbo_cmd_t  cmd
);

	localparam logic [4:0] ST_INIT  = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_DISP  = 5'd2;
	localparam logic [4:0] ST_SWEEP = 5'd3;
	localparam logic [4:0] ST_LRD   = 5'd4;
	localparam logic [4:0] ST_LCNT  = 5'd5;
	localparam logic [4:0] ST_LSCAN = 5'd6;
	localparam logic [4:0] ST_LWR   = 5'd7;
	localparam logic [4:0] ST_LNEXT = 5'd8;
	localparam logic [4:0] ST_CSCAN = 5'd9;
	localparam logic [4:0] ST_SEED  = 5'd10;
	localparam logic [4:0] ST_POP   = 5'd11;
	localparam logic [4:0] ST_NODE  = 5'd12;
	localparam logic [4:0] ST_DEG   = 5'd13;
	localparam logic [4:0] ST_NB    = 5'd14;
	localparam logic [4:0] ST_CHK   = 5'd15;
	localparam logic [4:0] ST_FIN   = 5'd16;

	logic [4:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	// next state and datapath operation
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			ST_INIT: begin
				cmd.op = OP_INIT;
				if (stat.init_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				cmd.op = OP_DISP;
				case (stat.kind)
					KIND_CLEAR:   state_d = stat.hn_zero ? ST_FIN : ST_SWEEP;
					KIND_ELEMENT: state_d = ST_LRD;
					KIND_COMPUTE: state_d = stat.hn_zero ? ST_FIN : ST_CSCAN;
					default:      state_d = ST_FIN;
				endcase
			end
			ST_SWEEP: begin
				cmd.op = OP_SWEEP;
				if (stat.clr_last) state_d = ST_FIN;
			end
			ST_LRD: begin
				cmd.op  = OP_LRD;
				state_d = ST_LCNT;
			end
			ST_LCNT: begin
				cmd.op  = OP_LCNT;
				state_d = stat.deg_zero ? ST_LWR : ST_LSCAN;
			end
			ST_LSCAN: begin
				cmd.op = OP_LSCAN;
				if (stat.match)     state_d = ST_LNEXT;
				else if (!stat.more) state_d = ST_LWR;
			end
			ST_LWR: begin
				cmd.op  = OP_LWR;
				state_d = stat.pair_last ? ST_FIN : ST_LRD;
			end
			ST_LNEXT: begin
				cmd.op  = OP_LNEXT;
				state_d = stat.pair_last ? ST_FIN : ST_LRD;
			end
			ST_CSCAN: begin
				cmd.op = OP_CSCAN;
				if (stat.scan_done) state_d = ST_SEED;
			end
			ST_SEED: begin
				cmd.op  = OP_SEED;
				state_d = ST_POP;
			end
			ST_POP: begin
				cmd.op  = OP_POP;
				state_d = stat.q_empty ? ST_FIN : ST_NODE;
			end
			ST_NODE: begin
				cmd.op  = OP_NODE;
				state_d = ST_DEG;
			end
			ST_DEG: begin
				cmd.op  = OP_DEG;
				state_d = stat.deg_zero ? ST_POP : ST_NB;
			end
			ST_NB: begin
				cmd.op  = OP_NB;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				cmd.op  = OP_CHK;
				state_d = stat.more ? ST_NB : ST_POP;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.op  = OP_FIN;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else         state_q <= state_d;
	end

endmodule

// ----- hw/rtl/mnbo_dp.sv -----
// ----------------------------------------------------------------------------
// mnbo_dp
// Datapath: neighbour lists, walk queue, marks and the result register.
// ----------------------------------------------------------------------------
module mnbo_dp import mnbo_pkg::*; #(
	parameter int MAX_DEGREE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mnbo_cmd_t           cmd,
	output mnbo_stat_t          stat,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata,
	input  logic [1:0]          kind,
	input  logic [NODE_W-1:0]   node0,
	input  logic [NODE_W-1:0]   node1,
	input  logic [NODE_W-1:0]   node2,
	input  logic [NODE_W-1:0]   node3,
	input  logic [NODE_W-1:0]   query_node,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic                used,
	output logic [NODE_W-1:0]   new_index,
	output logic [TOTAL_W-1:0]  used_count,
	output logic [TOTAL_W-1:0]  node_count
);

	localparam int DCW = $clog2(MAX_DEGREE + 1);
	localparam int DSW = $clog2(MAX_DEGREE);
	localparam int TAW = NODE_W + DSW;
	localparam int TAB_DEPTH = MAX_NODES << DSW;
	localparam logic [DCW-1:0] DEG_FULL = DCW'(MAX_DEGREE);

	// memories
	logic [DCW-1:0]    cnt_mem   [MAX_NODES];
	logic [NODE_W-1:0] tab_mem   [TAB_DEPTH];
	logic [NODE_W-1:0] mark_mem  [MAX_NODES];
	logic              seen_mem  [MAX_NODES];
	logic [NODE_W-1:0] queue_mem [MAX_NODES];

	logic [DCW-1:0]    cnt_rd_q;
	logic [NODE_W-1:0] tab_rd_q, mark_rd_q, queue_rd_q;
	logic              seen_rd_q;

	// registers
	logic [2:0]         cfg_q;
	logic [1:0]         kind_q;
	logic [NODE_W-1:0]  nodes_q [ELEM_MAX];
	logic [NODE_W-1:0]  qnode_q;
	logic [2:0]         ecnt_q;
	logic [TOTAL_W-1:0] hn_q, reached_q, sweep_q, head_q, tail_q;
	logic               ovf_q, comp_q;
	logic [1:0]         k_q, l_q;
	logic               dir_q;
	logic [DCW-1:0]     deg_q, slot_q, startdeg_q;
	logic [NODE_W-1:0]  cur_q, start_q, o_q;
	logic               oval_q;
	logic               pv_s1;
	logic [NODE_W-1:0]  pidx_s1;
	logic               out_valid_q;

	// link row and column for the current ordered pair
	logic [NODE_W-1:0] row, col;
	assign row = dir_q ? nodes_q[l_q] : nodes_q[k_q];
	assign col = dir_q ? nodes_q[k_q] : nodes_q[l_q];

	// next ordered pair
	logic [2:0] nl, nk;
	always_comb begin
		nk = {1'b0, k_q};
		nl = {1'b0, l_q} + 3'd1;
		if (nl == {1'b0, k_q}) nl = nl + 3'd1;
		if (nl >= ecnt_q) begin
			nk = {1'b0, k_q} + 3'd1;
			nl = 3'd0;
		end
	end

	// used node count of an element item, clamped
	logic [2:0] cnt_clamp;
	always_comb begin
		if (cfg_q < 3'd2)      cnt_clamp = 3'd2;
		else if (cfg_q > 3'd4) cnt_clamp = 3'd4;
		else                   cnt_clamp = cfg_q;
	end

	// highest node after an element item
	logic [TOTAL_W-1:0] hn_new;
	always_comb begin
		hn_new = hn_q;
		for (int i = 0; i < ELEM_MAX; i++) begin
			if (3'(i) < ecnt_q && ({1'b0, nodes_q[i]} + 13'd1) > hn_new)
				hn_new = {1'b0, nodes_q[i]} + 13'd1;
		end
	end

	logic [DCW-1:0] slot_inc;
	assign slot_inc = slot_q + DCW'(1);

	// status to the sequencer
	always_comb begin
		stat.kind      = kind_q;
		stat.hn_zero   = (hn_q == '0);
		stat.init_last = (sweep_q == TOTAL_W'(MAX_NODES - 1));
		stat.clr_last  = (sweep_q == hn_q - 13'd1);
		stat.deg_zero  = (cnt_rd_q == '0);
		stat.match     = (tab_rd_q == col);
		stat.more      = (slot_inc < deg_q);
		stat.pair_last = dir_q && ({1'b0, k_q} == ecnt_q - 3'd1)
			&& ({1'b0, l_q} == ecnt_q - 3'd2);
		stat.scan_done = (sweep_q == hn_q) && !pv_s1;
		stat.q_empty   = (head_q == tail_q);
		stat.out_free  = !out_valid_q || out_ready;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     cfg_q <= 3'd3;
		else if (cfg_we) cfg_q <= cfg_wdata;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hn_q        <= '0;
			reached_q   <= '0;
			sweep_q     <= '0;
			ovf_q       <= 1'b0;
			comp_q      <= 1'b0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_INIT: sweep_q <= sweep_q + 13'd1;
				OP_DISP: begin
					case (kind_q)
						KIND_CLEAR: begin
							ovf_q     <= 1'b0;
							comp_q    <= 1'b0;
							reached_q <= '0;
							sweep_q   <= '0;
						end
						KIND_ELEMENT: begin
							comp_q    <= 1'b0;
							reached_q <= '0;
							hn_q      <= hn_new;
						end
						KIND_COMPUTE: begin
							comp_q    <= 1'b1;
							reached_q <= '0;
							sweep_q   <= '0;
							pv_s1     <= 1'b0;
						end
						default: ;
					endcase
				end
				OP_SWEEP: begin
					sweep_q <= sweep_q + 13'd1;
					if (stat.clr_last) hn_q <= '0;
				end
				OP_LWR: if (deg_q == DEG_FULL) ovf_q <= 1'b1;
				OP_CSCAN: begin
					pv_s1 <= (sweep_q != hn_q);
					if (sweep_q != hn_q) sweep_q <= sweep_q + 13'd1;
				end
				OP_POP: if (stat.q_empty) reached_q <= tail_q;
				OP_FIN: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				kind_q     <= kind;
				nodes_q[0] <= node0;
				nodes_q[1] <= node1;
				nodes_q[2] <= node2;
				nodes_q[3] <= node3;
				qnode_q    <= query_node;
				ecnt_q     <= cnt_clamp;
			end
			OP_DISP: begin
				k_q        <= 2'd0;
				l_q        <= 2'd1;
				dir_q      <= 1'b0;
				start_q    <= '0;
				startdeg_q <= '0;
			end
			OP_LCNT: begin
				deg_q  <= cnt_rd_q;
				slot_q <= '0;
			end
			OP_LSCAN: slot_q <= slot_inc;
			OP_LWR, OP_LNEXT: begin
				if (dir_q) begin
					dir_q <= 1'b0;
					k_q   <= nk[1:0];
					l_q   <= nl[1:0];
				end else begin
					dir_q <= 1'b1;
				end
			end
			OP_CSCAN: begin
				pidx_s1 <= sweep_q[NODE_W-1:0];
				if (pv_s1 && (startdeg_q == '0 || startdeg_q > cnt_rd_q)
					&& cnt_rd_q != '0) begin
					start_q    <= pidx_s1;
					startdeg_q <= cnt_rd_q;
				end
			end
			OP_SEED: begin
				head_q <= '0;
				tail_q <= 13'd1;
			end
			OP_NODE: begin
				cur_q  <= queue_rd_q;
				head_q <= head_q + 13'd1;
			end
			OP_DEG: begin
				deg_q  <= cnt_rd_q;
				slot_q <= '0;
			end
			OP_NB: begin
				o_q    <= tab_rd_q;
				oval_q <= ({1'b0, tab_rd_q} < hn_q);
			end
			OP_CHK: begin
				slot_q <= slot_inc;
				if (oval_q && !seen_rd_q) tail_q <= tail_q + 13'd1;
			end
			OP_FIN: begin
				status     <= (kind_q == KIND_QUERY && !comp_q) ? STATUS_NO_ORDER :
					(ovf_q ? STATUS_OVERFLOW : STATUS_OK);
				used       <= 1'b0;
				new_index  <= '0;
				used_count <= reached_q;
				node_count <= hn_q;
				if (kind_q == KIND_QUERY && comp_q && {1'b0, qnode_q} < hn_q && seen_rd_q) begin
					used      <= 1'b1;
					new_index <= NODE_W'(reached_q - 13'd1 - {1'b0, mark_rd_q});
				end
			end
			default: ;
		endcase
	end

	// neighbour count memory
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INIT, OP_SWEEP: cnt_mem[sweep_q[NODE_W-1:0]] <= '0;
			OP_LWR: if (deg_q != DEG_FULL) cnt_mem[row] <= deg_q + DCW'(1);
			default: ;
		endcase
		case (cmd.op)
			OP_LRD:   cnt_rd_q <= cnt_mem[row];
			OP_CSCAN: cnt_rd_q <= cnt_mem[sweep_q[NODE_W-1:0]];
			OP_NODE:  cnt_rd_q <= cnt_mem[queue_rd_q];
			default: ;
		endcase
	end

	// neighbour table memory
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LWR && deg_q != DEG_FULL)
			tab_mem[TAW'({row, deg_q[DSW-1:0]})] <= col;
		case (cmd.op)
			OP_LCNT:  tab_rd_q <= tab_mem[TAW'({row, {DSW{1'b0}}})];
			OP_LSCAN: tab_rd_q <= tab_mem[TAW'({row, slot_inc[DSW-1:0]})];
			OP_DEG:   tab_rd_q <= tab_mem[TAW'({cur_q, {DSW{1'b0}}})];
			OP_CHK:   tab_rd_q <= tab_mem[TAW'({cur_q, slot_inc[DSW-1:0]})];
			default: ;
		endcase
	end

	// reached bits
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CSCAN: if (sweep_q != hn_q) seen_mem[sweep_q[NODE_W-1:0]] <= 1'b0;
			OP_SEED:  seen_mem[start_q] <= 1'b1;
			OP_CHK:   if (oval_q && !seen_rd_q) seen_mem[o_q] <= 1'b1;
			default: ;
		endcase
		case (cmd.op)
			OP_DISP: seen_rd_q <= seen_mem[qnode_q];
			OP_NB:   seen_rd_q <= seen_mem[tab_rd_q];
			default: ;
		endcase
	end

	// walk queue
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SEED: queue_mem[0] <= start_q;
			OP_CHK:  if (oval_q && !seen_rd_q) queue_mem[tail_q[NODE_W-1:0]] <= o_q;
			default: ;
		endcase
		if (cmd.op == OP_POP) queue_rd_q <= queue_mem[head_q[NODE_W-1:0]];
	end

	// visit order marks
	always_ff @(posedge clk) begin
		if (cmd.op == OP_NODE) mark_mem[queue_rd_q] <= head_q[NODE_W-1:0];
		if (cmd.op == OP_DISP) mark_rd_q <= mark_mem[qnode_q];
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/mnbo_checker.sv -----
// ----------------------------------------------------------------------------
// mnbo_checker
// Port-level checks of the ordering block, bound to its top level.
// ----------------------------------------------------------------------------
module mnbo_checker import mnbo_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic               used,
	input logic [NODE_W-1:0]  new_index,
	input logic [TOTAL_W-1:0] used_count
);

	// a result that is not taken stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(new_index))
		else $error("result dropped or changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// a reached node has an index inside the walk
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && used |-> {1'b0, new_index} < used_count)
		else $error("new index beyond reached count");

	// a reached node comes only with a valid ordering
	a_used_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && used |-> status == STATUS_OK || status == STATUS_OVERFLOW)
		else $error("used node without an ordering");

endmodule

bind mesh_node_bandwidth_ordering mnbo_checker u_mnbo_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.used       (used),
	.new_index  (new_index),
	.used_count (used_count)
);

// ----- test/mesh_node_bandwidth_ordering_tb.sv -----
// ----------------------------------------------------------------------------
// mesh_node_bandwidth_ordering_tb
// Drives clear, element, compute and query requests into the ordering block
// through a valid/ready driver fed from a queue, predicts every result with
// an in-bench model of the neighbour lists and the reverse breadth-first walk,
// and checks each result field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module mesh_node_bandwidth_ordering_tb;
	import mnbo_pkg::*;

	localparam int DEGREE_MAX = 16;
	localparam int STALL_LIMIT = 300000;
	localparam int ITEM_TARGET = 650;

	typedef struct packed {
		logic [1:0]        kind;
		logic [NODE_W-1:0] n0;
		logic [NODE_W-1:0] n1;
		logic [NODE_W-1:0] n2;
		logic [NODE_W-1:0] n3;
		logic [NODE_W-1:0] qn;
	} request_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               used;
		logic [NODE_W-1:0]  new_index;
		logic [TOTAL_W-1:0] used_count;
		logic [TOTAL_W-1:0] node_count;
	} answer_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [2:0]          cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          kind;
	logic [NODE_W-1:0]   node0, node1, node2, node3, query_node;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic                used;
	logic [NODE_W-1:0]   new_index;
	logic [TOTAL_W-1:0]  used_count;
	logic [TOTAL_W-1:0]  node_count;

	mesh_node_bandwidth_ordering uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.node0(node0), .node1(node1), .node2(node2), .node3(node3),
		.query_node(query_node), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .used(used), .new_index(new_index),
		.used_count(used_count), .node_count(node_count)
	);

	// predictor state
	int          deg_of [MAX_NODES];
	int          nbr_of [MAX_NODES][DEGREE_MAX];
	int          order_of [MAX_NODES];
	bit          reached [MAX_NODES];
	int          walk [MAX_NODES];
	int          top_node;
	bit          list_full;
	bit          order_valid;
	int          reached_cnt;
	int          elem_nodes;

	request_t    pending_reqs [$];
	answer_t     expected_answers [$];
	int          queued_total;
	int          taken_total;
	int          errors;
	int          idle_cycles;
	bit          req_taken;
	bit          calm;
	int          in_gap;
	int          out_gap;
	int          item_cnt;

	always #6 clk = ~clk;

	// neighbour list insert with duplicate check
	function automatic void add_link(int row, int col);
		for (int i = 0; i < deg_of[row]; i++)
			if (nbr_of[row][i] == col) return;
		if (deg_of[row] >= DEGREE_MAX) begin
			list_full = 1;
			return;
		end
		nbr_of[row][deg_of[row]] = col;
		deg_of[row]++;
	endfunction

	function automatic void add_element(request_t r);
		int nd [4];
		int cnt;
		cnt = elem_nodes < 2 ? 2 : (elem_nodes > 4 ? 4 : elem_nodes);
		nd[0] = r.n0; nd[1] = r.n1; nd[2] = r.n2; nd[3] = r.n3;
		order_valid = 0;
		reached_cnt = 0;
		for (int k = 0; k < cnt; k++)
			if (nd[k] + 1 > top_node) top_node = nd[k] + 1;
		for (int k = 0; k < cnt; k++)
			for (int l = 0; l < cnt; l++)
				if (k != l) begin
					add_link(nd[k], nd[l]);
					add_link(nd[l], nd[k]);
				end
	endfunction

	// breadth-first walk from the lowest node of smallest nonzero degree
	function automatic void build_order();
		int n, start, head, tail, id, c, o;
		n = top_node;
		order_valid = 1;
		reached_cnt = 0;
		if (n == 0) return;
		start = 0;
		for (int i = 0; i < n; i++) begin
			reached[i] = 0;
			if ((deg_of[start] == 0 || deg_of[start] > deg_of[i]) && deg_of[i] != 0)
				start = i;
		end
		walk[0] = start;
		reached[start] = 1;
		head = 0;
		tail = 1;
		id = 0;
		while (head < tail) begin
			c = walk[head];
			head++;
			order_of[c] = id;
			id++;
			for (int j = 0; j < deg_of[c]; j++) begin
				o = nbr_of[c][j];
				if (o < n && !reached[o] && tail < n) begin
					reached[o] = 1;
					walk[tail] = o;
					tail++;
				end
			end
		end
		for (int i = 0; i < n; i++)
			if (reached[i]) order_of[i] = id - 1 - order_of[i];
		reached_cnt = id;
	endfunction

	function automatic answer_t predict_answer(request_t r);
		answer_t a;
		case (r.kind)
			KIND_CLEAR: begin
				for (int i = 0; i < MAX_NODES; i++) deg_of[i] = 0;
				top_node = 0;
				list_full = 0;
				order_valid = 0;
				reached_cnt = 0;
			end
			KIND_ELEMENT: add_element(r);
			KIND_COMPUTE: build_order();
			default: ;
		endcase
		a = '0;
		a.status = list_full ? STATUS_OVERFLOW : STATUS_OK;
		if (r.kind == KIND_QUERY) begin
			if (!order_valid)
				a.status = STATUS_NO_ORDER;
			else if (r.qn < top_node && reached[r.qn]) begin
				a.used = 1;
				a.new_index = order_of[r.qn];
			end
		end
		a.used_count = reached_cnt;
		a.node_count = top_node;
		return a;
	endfunction

	task automatic push_req(logic [1:0] k, int a, int b, int c, int d, int q);
		request_t r;
		r.kind = k; r.n0 = a; r.n1 = b; r.n2 = c; r.n3 = d; r.qn = q;
		pending_reqs.push_back(r);
		queued_total++;
		item_cnt++;
	endtask

	task automatic wait_drained();
		while (taken_total != queued_total || expected_answers.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_elem_nodes(int v);
		wait_drained();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		elem_nodes = v;
	endtask

	// accept requests, predict, and check results
	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_answers.push_back(predict_answer({kind, node0, node1, node2,
					node3, query_node}));
				taken_total++;
				req_taken = 1;
			end
			if (out_valid && out_ready) begin
				got = {status, used, new_index, used_count, node_count};
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					errors++;
				end else begin
					want = expected_answers.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
						errors++;
					end
					if (got.used !== want.used) begin
						$display("%0t: used expected %0d actual %0d", $time,
							want.used, got.used);
						errors++;
					end
					if (got.new_index !== want.new_index) begin
						$display("%0t: new_index expected %0d actual %0d", $time,
							want.new_index, got.new_index);
						errors++;
					end
					if (got.used_count !== want.used_count) begin
						$display("%0t: used_count expected %0d actual %0d", $time,
							want.used_count, got.used_count);
						errors++;
					end
					if (got.node_count !== want.node_count) begin
						$display("%0t: node_count expected %0d actual %0d", $time,
							want.node_count, got.node_count);
						errors++;
					end
				end
			end
			// watchdog on cycles with no handshake
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		request_t r;
		if (arst_n && (!in_valid || req_taken)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 0;
			end else if (pending_reqs.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
				in_gap = $urandom_range(0, 13);
				in_valid <= 0;
			end else if (pending_reqs.size() != 0) begin
				r = pending_reqs.pop_front();
				kind <= r.kind;
				node0 <= r.n0; node1 <= r.n1; node2 <= r.n2; node3 <= r.n3;
				query_node <= r.qn;
				in_valid <= 1;
			end else
				in_valid <= 0;
		end
		req_taken = 0;
	end

	// result stalls
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_ready <= 0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			out_gap = $urandom_range(0, 13);
			out_ready <= 0;
		end else
			out_ready <= 1;
	end

	function automatic int pick_node(int span);
		if ($urandom_range(0, 40) == 0) return $urandom_range(0, 4095);
		return $urandom_range(0, span);
	endfunction

	initial begin
		int span, n_elem, n_query, cfg_vals [8];
		int ph;
		clk = 0; arst_n = 0; cfg_we = 0; cfg_wdata = 0;
		in_valid = 0; out_ready = 0; kind = KIND_CLEAR;
		node0 = 0; node1 = 0; node2 = 0; node3 = 0; query_node = 0;
		errors = 0; idle_cycles = 0; req_taken = 0; calm = 0;
		in_gap = 0; out_gap = 0; queued_total = 0; taken_total = 0; item_cnt = 0;
		for (int i = 0; i < MAX_NODES; i++) begin
			deg_of[i] = 0;
			reached[i] = 0;
		end
		top_node = 0; list_full = 0; order_valid = 0; reached_cnt = 0;
		elem_nodes = 3;
		repeat (10) @(negedge clk);
		arst_n = 1;

		// directed: stale query, extremes, repeated node, self-check of ranges
		push_req(KIND_QUERY, 0, 0, 0, 0, 0);
		push_req(KIND_COMPUTE, 0, 0, 0, 0, 0);
		push_req(KIND_QUERY, 4095, 4095, 4095, 4095, 4095);
		push_req(KIND_ELEMENT, 0, 4095, 7, 0, 0);
		push_req(KIND_QUERY, 0, 0, 0, 0, 5);
		push_req(KIND_ELEMENT, 9, 9, 10, 3, 0);
		push_req(KIND_COMPUTE, 0, 0, 0, 0, 0);
		push_req(KIND_QUERY, 0, 0, 0, 0, 0);
		push_req(KIND_QUERY, 0, 0, 0, 0, 4095);
		push_req(KIND_QUERY, 0, 0, 0, 0, 9);
		push_req(KIND_QUERY, 0, 0, 0, 0, 100);
		push_req(KIND_CLEAR, 4095, 4095, 4095, 4095, 4095);
		push_req(KIND_COMPUTE, 0, 0, 0, 0, 0);
		push_req(KIND_QUERY, 0, 0, 0, 0, 0);
		write_elem_nodes(2);
		// neighbour list overflow on node 1
		for (int i = 2; i < 20; i++) push_req(KIND_ELEMENT, 1, i, 0, 0, 0);
		push_req(KIND_ELEMENT, 1, 2, 0, 0, 0);
		push_req(KIND_COMPUTE, 0, 0, 0, 0, 0);
		push_req(KIND_QUERY, 0, 0, 0, 0, 1);
		push_req(KIND_QUERY, 0, 0, 0, 0, 19);
		push_req(KIND_CLEAR, 0, 0, 0, 0, 0);

		// random phases over register settings, extremes included
		cfg_vals = '{0, 4, 7, 1, 3, 5, 2, 6};
		ph = 0;
		while (item_cnt < ITEM_TARGET) begin
			write_elem_nodes(ph < 8 ? cfg_vals[ph] : $urandom_range(0, 7));
			if (item_cnt > ITEM_TARGET - 70) calm = 1;
			span = $urandom_range(3, 40);
			n_elem = $urandom_range(3, 30);
			n_query = $urandom_range(3, 10);
			push_req(KIND_CLEAR, pick_node(4095), 0, 0, 0, 0);
			for (int i = 0; i < n_elem; i++)
				push_req(KIND_ELEMENT, pick_node(span), pick_node(span), pick_node(span),
					pick_node(span), pick_node(4095));
			push_req(KIND_COMPUTE, 0, 0, 0, 0, 0);
			for (int i = 0; i < n_query; i++)
				push_req(KIND_QUERY, 0, 0, 0, 0, pick_node(span + 2));
			// noise: stale ordering or a stray request
			if ($urandom_range(0, 2) == 0) begin
				push_req(KIND_ELEMENT, pick_node(span), pick_node(span), pick_node(span),
					pick_node(span), 0);
				push_req(KIND_QUERY, 0, 0, 0, 0, pick_node(span));
			end
			if ($urandom_range(0, 3) == 0)
				push_req($urandom_range(0, 3), pick_node(4095), pick_node(4095),
					pick_node(4095), pick_node(4095), pick_node(4095));
			ph++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
